[hdl/lhlb_pkg.sv]
// shared types, constants and codes of the label histogram block
`default_nettype none

package lhlb_pkg;

	localparam int LABEL_W         = 8;
	localparam int COUNT_W         = 21;
	localparam int BLOB_W          = 9;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;
	localparam int LABEL_COUNT_DEF = 256;

	localparam logic [COUNT_W-1:0] COUNT_MAX    = 21'd2097151;
	localparam logic [COUNT_W-1:0] THRESH_RESET = 21'd100;
	localparam int                 BLOB_MAX     = 511;

	// input command codes
	localparam logic CMD_ACCUM    = 1'b0;
	localparam logic CMD_CLASSIFY = 1'b1;

	// result kinds
	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_PIXEL   = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_SURVEY = 1'b0;
	localparam logic REG_THRESH = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic pix_acc;     // accumulate pixel transferred
		logic cls_load;    // classify pixel transferred, load result
		logic sweep_en;    // step the histogram sweep (read and zero)
		logic sweep_scan;  // sweep feeds the frame scan
		logic track_init;  // restart the scan trackers
		logic sum_load;    // load the frame summary
	} lhlb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_last;  // sweep is at the final entry
		logic out_full;    // output register holds a result
	} lhlb_status_t;

endpackage : lhlb_pkg

`default_nettype wire

[hdl/label_histogram_largest_blob.sv]
// top level: label histogram with background and largest component pick
// accumulate: one pixel transfer per cycle while the input is not stalled, counted by the ram write from the s1 pipe
// classify: one pixel transfer per cycle unless the output is stalled, result in the output register the cycle after
// last accumulate pixel: drain, scan sweep over the histogram, tail and summary load follow, input stalled meanwhile
// reset: clearing pass over all LABEL_COUNT histogram entries, input stalled meanwhile
// reset also gives survey_mode 0, size_threshold 100, background and largest label 0
`default_nettype none

module label_histogram_largest_blob #(
	parameter int LABEL_COUNT = lhlb_pkg::LABEL_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// pixel input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          command,
	input  wire logic [lhlb_pkg::LABEL_W-1:0]  label,
	input  wire logic                          last_pixel,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               kind,
	output logic      [lhlb_pkg::BLOB_W-1:0]   blob_count,
	output logic      [lhlb_pkg::LABEL_W-1:0]  background_label,
	output logic      [lhlb_pkg::LABEL_W-1:0]  largest_label,
	output logic                               largest_mask,
	output logic                               leftover_mask,
	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lhlb_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [lhlb_pkg::PDATA_W-1:0]  pwdata,
	output logic      [lhlb_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready
);

	lhlb_pkg::lhlb_cmd_t    cmd;
	lhlb_pkg::lhlb_status_t status;

	logic                            survey_q;
	logic [lhlb_pkg::COUNT_W-1:0]    thresh_q;
	logic                            cfg_wr;

	// configuration registers, written on the access phase of a transfer
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			survey_q <= 1'b0;
			thresh_q <= lhlb_pkg::THRESH_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				lhlb_pkg::REG_SURVEY: survey_q <= pwdata[0];
				lhlb_pkg::REG_THRESH: thresh_q <= pwdata[lhlb_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// readback
	always_comb begin
		unique case (paddr[2])
			lhlb_pkg::REG_SURVEY: prdata = lhlb_pkg::PDATA_W'(survey_q);
			lhlb_pkg::REG_THRESH: prdata = lhlb_pkg::PDATA_W'(thresh_q);
			default:              prdata = '0;
		endcase
	end

	// sequencing: clear after reset, stream pixels, drain, scan, summary
	lhlb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.command    (command),
		.last_pixel (last_pixel),
		.out_stall  (out_stall),
		.status     (status),
		.in_stall   (in_stall),
		.cmd        (cmd)
	);

	// histogram ram, top-two scan and the output register
	lhlb_datapath #(
		.LABEL_COUNT (LABEL_COUNT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.label            (label),
		.survey_mode      (survey_q),
		.size_threshold   (thresh_q),
		.out_stall        (out_stall),
		.status           (status),
		.out_valid        (out_valid),
		.kind             (kind),
		.blob_count       (blob_count),
		.background_label (background_label),
		.largest_label    (largest_label),
		.largest_mask     (largest_mask),
		.leftover_mask    (leftover_mask)
	);

`ifndef NO_ASSERTIONS
	// a result is never loaded over one that is stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cls_load || cmd.sum_load) |-> !(out_valid && out_stall))
		else $error("result loaded over a stalled result");

	// the sweep never starts while a pixel write is still pending
	a_sweep_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_en |-> !$past(cmd.pix_acc))
		else $error("sweep overlaps a pixel update");

	// a loaded summary is offered on the next cycle
	a_summary_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum_load |=> (out_valid && kind == lhlb_pkg::KIND_SUMMARY))
		else $error("summary not presented after load");
`endif

endmodule : label_histogram_largest_blob

`default_nettype wire

[hdl/lhlb_ram.sv]
// generic simple dual port ram with registered read, read-first
`default_nettype none

module lhlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule : lhlb_ram

`default_nettype wire

[hdl/lhlb_datapath.sv]
// histogram memory, pixel update pipe, frame scan and output register
`default_nettype none

module lhlb_datapath #(
	parameter int LABEL_COUNT = lhlb_pkg::LABEL_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lhlb_pkg::lhlb_cmd_t           cmd,
	input  wire logic [lhlb_pkg::LABEL_W-1:0]  label,
	input  wire logic                          survey_mode,
	input  wire logic [lhlb_pkg::COUNT_W-1:0]  size_threshold,
	input  wire logic                          out_stall,
	output lhlb_pkg::lhlb_status_t             status,
	output logic                               out_valid,
	output logic                               kind,
	output logic      [lhlb_pkg::BLOB_W-1:0]   blob_count,
	output logic      [lhlb_pkg::LABEL_W-1:0]  background_label,
	output logic      [lhlb_pkg::LABEL_W-1:0]  largest_label,
	output logic                               largest_mask,
	output logic                               leftover_mask
);

	localparam int ADDR_W = $clog2(LABEL_COUNT);
	localparam int TOT_W  = $clog2(LABEL_COUNT + 1);
	localparam int CW     = lhlb_pkg::COUNT_W;
	localparam int LW     = lhlb_pkg::LABEL_W;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CW-1:0]     ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CW-1:0]     ram_rdata;

	logic              pix_vld_s1;
	logic [ADDR_W-1:0] pix_addr_s1;
	logic              fwd_vld_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [CW-1:0]     fwd_cnt_q;
	logic [CW-1:0]     cur_cnt;
	logic [CW-1:0]     inc_cnt;
	logic              in_range;

	logic [ADDR_W-1:0] sweep_addr_q;
	logic              scan_vld_s1;
	logic [ADDR_W-1:0] scan_idx_s1;

	logic [CW-1:0]     m1_q;
	logic [CW-1:0]     m2_q;
	logic [ADDR_W-1:0] i1_q;
	logic [ADDR_W-1:0] i2_q;
	logic [TOT_W-1:0]  tot_q;

	logic [TOT_W-1:0]  blob_sub;
	logic [lhlb_pkg::BLOB_W-1:0] blob_sum;
	logic [LW-1:0]     bg_sum;
	logic [LW-1:0]     lg_sum;
	logic              m1_over;
	logic              m2_over;

	logic [LW-1:0]     bg_q;
	logic [LW-1:0]     lg_q;

	lhlb_ram #(
		.WIDTH (CW),
		.DEPTH (LABEL_COUNT)
	) u_hist (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// pixel update: forward the previous write to cover the read-first hazard
	assign in_range  = (32'(label) < LABEL_COUNT);
	assign cur_cnt   = (fwd_vld_q && (fwd_addr_q == pix_addr_s1)) ? fwd_cnt_q : ram_rdata;
	assign inc_cnt   = (cur_cnt == lhlb_pkg::COUNT_MAX) ? cur_cnt : cur_cnt + CW'(1);

	assign ram_raddr = cmd.sweep_en ? sweep_addr_q : ADDR_W'(label);
	assign ram_we    = pix_vld_s1 || cmd.sweep_en;
	assign ram_waddr = pix_vld_s1 ? pix_addr_s1 : sweep_addr_q;
	assign ram_wdata = pix_vld_s1 ? inc_cnt : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_vld_s1 <= 1'b0;
			fwd_vld_q  <= 1'b0;
		end else begin
			pix_vld_s1 <= cmd.pix_acc && in_range;
			fwd_vld_q  <= pix_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pix_addr_s1 <= ADDR_W'(label);
		fwd_addr_q  <= pix_addr_s1;
		fwd_cnt_q   <= inc_cnt;
	end

	// sweep over all entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q <= '0;
			scan_vld_s1  <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.sweep_en && cmd.sweep_scan;
			if (cmd.sweep_en) begin
				sweep_addr_q <= status.sweep_last ? '0 : sweep_addr_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= sweep_addr_q;
	end

	// top two tracking, strict compares keep the first index on ties
	always_ff @(posedge clk) begin
		if (cmd.track_init) begin
			m1_q  <= '0;
			i1_q  <= '0;
			m2_q  <= '0;
			i2_q  <= '0;
			tot_q <= '0;
		end else if (scan_vld_s1) begin
			if (ram_rdata > m1_q) begin
				m2_q <= m1_q;
				i2_q <= i1_q;
				m1_q <= ram_rdata;
				i1_q <= scan_idx_s1;
			end else if (ram_rdata > m2_q) begin
				m2_q <= ram_rdata;
				i2_q <= scan_idx_s1;
			end
			if (ram_rdata > size_threshold) begin
				tot_q <= tot_q + TOT_W'(1);
			end
		end
	end

	// summary: drop background and, in survey mode, largest from the total
	assign m1_over  = (m1_q > size_threshold);
	assign m2_over  = survey_mode && (m2_q > size_threshold);
	assign blob_sub = tot_q - TOT_W'(m1_over) - TOT_W'(m2_over);
	assign blob_sum = (32'(blob_sub) > lhlb_pkg::BLOB_MAX) ?
		lhlb_pkg::BLOB_W'(lhlb_pkg::BLOB_MAX) : lhlb_pkg::BLOB_W'(blob_sub);
	assign bg_sum   = LW'(i1_q);
	// no other label present: largest reads as label zero
	assign lg_sum   = (m2_q == '0) ? '0 : LW'(i2_q);

	assign status.sweep_last = (sweep_addr_q == ADDR_W'(LABEL_COUNT - 1));
	assign status.out_full   = out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			bg_q      <= '0;
			lg_q      <= '0;
		end else begin
			if (cmd.cls_load || cmd.sum_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (cmd.sum_load) begin
				bg_q <= bg_sum;
				lg_q <= lg_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_load) begin
			kind             <= lhlb_pkg::KIND_SUMMARY;
			blob_count       <= blob_sum;
			background_label <= bg_sum;
			largest_label    <= lg_sum;
			largest_mask     <= 1'b0;
			leftover_mask    <= 1'b0;
		end else if (cmd.cls_load) begin
			kind             <= lhlb_pkg::KIND_PIXEL;
			blob_count       <= '0;
			background_label <= bg_q;
			largest_label    <= lg_q;
			largest_mask     <= survey_mode && (label == lg_q);
			leftover_mask    <= survey_mode && (label != lg_q) && (label != bg_q);
		end
	end

endmodule : lhlb_datapath

`default_nettype wire

[hdl/lhlb_ctrl.sv]
// controller state machine: clear, stream, drain, scan and summary
`default_nettype none

module lhlb_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   command,
	input  wire logic                   last_pixel,
	input  wire logic                   out_stall,
	input  wire lhlb_pkg::lhlb_status_t status,
	output logic                        in_stall,
	output lhlb_pkg::lhlb_cmd_t         cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_TAIL  = 3'd4;
	localparam logic [2:0] ST_SUM   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_blocked;
	logic       accept;

	assign out_blocked = status.out_full && out_stall;

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		accept   = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.sweep_en = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				// accumulate pixels need no output slot
				in_stall     = (command == lhlb_pkg::CMD_CLASSIFY) && out_blocked;
				accept       = in_valid && !in_stall;
				cmd.pix_acc  = accept && (command == lhlb_pkg::CMD_ACCUM);
				cmd.cls_load = accept && (command == lhlb_pkg::CMD_CLASSIFY);
				if (cmd.pix_acc && last_pixel) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.track_init = 1'b1;
				state_d        = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.sweep_en   = 1'b1;
				cmd.sweep_scan = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				if (!out_blocked) begin
					cmd.sum_load = 1'b1;
					state_d      = ST_RUN;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule : lhlb_ctrl

`default_nettype wire
